FILE: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the lightness cross sharpen
// Field widths, register indexes, queue sizing and the job record that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package lcs_pkg;

   // Payload widths of the two channels.
   localparam int LIGHT_W = 15;
   localparam int SHARP_W = 9;
   localparam int FRAC_W  = 8;

   // Request kinds.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_DRAIN  = 1'b1;

   // Configuration registers.
   localparam int FW_W       = 12;
   localparam int FH_W       = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

   // Arithmetic: gain on the centre, rounding bias and result ceiling.
   localparam int POS_W       = 18;
   localparam int NEG_W       = 17;
   localparam int DIFF_W      = 19;
   localparam int QUO_W       = DIFF_W - 1 - FRAC_W;
   localparam int CENTRE_GAIN = 5;
   localparam int ROUND_BIAS  = 128;
   localparam int RESULT_MAX  = 511;

   // Queue between front and back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Effective frame configuration seen by the front end.
   typedef struct packed {
      logic [FW_W-1:0] frame_width;
      logic [FH_W-1:0] frame_height;
   } cfg_type;

   // One pixel's work: weighted centre, neighbour sum and end flags.
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [NEG_W-1:0] neg;
      logic             row_end;
      logic             frame_end;
   } job_type;

endpackage

FILE: rtl/lcs_req_if.sv
// ----------------------------------------------------------------------------
// lcs_req_if: request channel
// Valid/ready channel carrying lightness samples and drain ticks.
// ----------------------------------------------------------------------------
interface lcs_req_if
   import lcs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [LIGHT_W-1:0] lightness;

   modport source (output valid, output req_type, output lightness, input ready);
   modport sink   (input valid, input req_type, input lightness, output ready);
endinterface

FILE: rtl/lcs_rsp_if.sv
// ----------------------------------------------------------------------------
// lcs_rsp_if: response channel
// Valid/ready channel carrying sharpened pixels and their row and frame flags.
// ----------------------------------------------------------------------------
interface lcs_rsp_if
   import lcs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [SHARP_W-1:0] sharpened;
   logic               row_end;
   logic               frame_end;

   modport source (output valid, output sharpened, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input sharpened, input row_end, input frame_end,
                   output ready);
endinterface

FILE: rtl/lightness_cross_sharpen.sv
// ----------------------------------------------------------------------------
// lightness_cross_sharpen: streaming five-point Laplacian sharpen
// Top level joining the register file, front end, job queue and back end.
// ----------------------------------------------------------------------------
// Lightness samples (unsigned, 8 fractional bits) enter in raster order at up
// to one beat per clock, and each sample of row y yields the sharpened pixel
// of row y-1 in the same column; row 0 yields nothing, and after the last row
// one drain beat per pixel flushes the final row. A result passes through the
// second stage, the job queue and the response register, and is then held until
// taken; a four-entry job queue lets request and response sides stall on their
// own, and outside the clearing sweep the request side holds off only when the
// queue, together with the job in the stage feeding it, holds four jobs. Each
// row store is one memory with a write port and two read ports, which is what
// allows one pixel per clock. After reset the block zeroes both row stores,
// one entry per cycle, and so accepts no request beat until all MAX_WIDTH
// entries (2048 by default) are cleared; register writes are taken throughout.
module lightness_cross_sharpen
   import lcs_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   lcs_req_if.sink               req_bus,
   lcs_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type           cfg;
   logic              push;
   job_type           push_job;
   logic              pop;
   job_type           head_job;
   logic              head_valid;
   logic [QCNT_W-1:0] q_count;

   // Frame configuration.
   lcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Raster tracking and row stores.
   lcs_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_bus  (req_bus),
      .q_count  (q_count),
      .push     (push),
      .push_job (push_job)
   );

   // Jobs waiting for the back end.
   lcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .count      (q_count)
   );

   // Rounding, clamping and the response register.
   lcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: rtl/lcs_csr.sv
// ----------------------------------------------------------------------------
// lcs_csr: configuration registers
// APB-style register file holding the frame width and frame height.
// ----------------------------------------------------------------------------
module lcs_csr
   import lcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [FW_W-1:0] frame_width_ff, frame_width_in;
   logic [FH_W-1:0] frame_height_ff, frame_height_in;
   logic            wr_beat;
   logic            reg_index;

   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1];

   // Register update on the access phase of a write.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (wr_beat) begin
         case (reg_index)
            REG_FRAME_WIDTH:  frame_width_in  = csr_pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_pwdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Read-back mux.
   always_comb begin
      case (reg_index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;

endmodule

FILE: rtl/lcs_front.sv
// ----------------------------------------------------------------------------
// lcs_front: request acceptance, raster tracking and line stores
// Classifies each request beat, keeps the column, row, swap and drain state,
// writes the two row stores and reads the neighbours of the pixel that is due.
// In the cycle after, it forms the weighted centre and the neighbour sum and
// pushes them into the queue.
// ----------------------------------------------------------------------------
module lcs_front
   import lcs_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   lcs_req_if.sink           req_bus,
   input  logic [QCNT_W-1:0] q_count,
   output logic              push,
   output job_type           push_job
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int XW = CW + 1;
   localparam logic [XW-1:0] MAX_W    = XW'(MAX_WIDTH);
   localparam logic [CW-1:0] LAST_IDX = CW'(MAX_WIDTH - 1);

   // Row stores: one holds the previous row, the other the row before it.
   logic [LIGHT_W-1:0] store_a [MAX_WIDTH];
   logic [LIGHT_W-1:0] store_b [MAX_WIDTH];
   logic [LIGHT_W-1:0] rd_a0_ff, rd_a1_ff, rd_b0_ff, rd_b1_ff;

   // Control state.
   logic          clearing_ff, clearing_in;
   logic [CW-1:0] clear_idx_ff, clear_idx_in;
   logic [CW-1:0] col_ff, col_in;
   logic [FH_W-1:0] row_ff, row_in;
   logic          swap_ff, swap_in;
   logic          draining_ff, draining_in;
   logic          s2_valid_ff, s2_valid_in;

   // Second stage payload.
   logic               s2_swap_ff, s2_has_left_ff, s2_has_right_ff, s2_use_up_ff;
   logic               s2_row_end_ff, s2_frame_end_ff;
   logic [LIGHT_W-1:0] s2_down_ff;
   logic [LIGHT_W-1:0] left_ff;

   // Combinational decode.
   logic [XW-1:0]     w_eff;
   logic [FH_W-1:0]   h_eff;
   logic              req_acc;
   logic              is_drain;
   logic              emit;
   logic              use_up;
   logic [XW-1:0]     col_next;
   logic              row_end;
   logic [FH_W:0]     row_next;
   logic              frame_done;
   logic              write_en;
   logic [CW-1:0]     right_idx;
   logic [QCNT_W:0]   occupancy;
   logic [LIGHT_W-1:0] cen, rgt, upr, lft;

   // Effective width and height: zero reads as one, width capped at the store depth.
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = XW'(1);
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         w_eff = MAX_W;
      end else begin
         w_eff = XW'(cfg.frame_width);
      end
      h_eff = (cfg.frame_height == '0) ? FH_W'(1) : cfg.frame_height;
   end

   // Accept while the queue has room for everything already in flight.
   assign occupancy     = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s2_valid_ff);
   assign req_bus.ready = !clearing_ff && (occupancy < (QCNT_W+1)'(QUEUE_DEPTH));
   assign req_acc       = req_bus.valid && req_bus.ready;

   // Classify the beat against the raster position.
   assign is_drain   = (req_bus.req_type == REQ_DRAIN);
   assign emit       = draining_ff ? is_drain : (!is_drain && (row_ff != '0));
   assign use_up     = draining_ff ? (row_ff != '0) : (row_ff > FH_W'(1));
   assign col_next   = {1'b0, col_ff} + XW'(1);
   assign row_end    = (col_next >= w_eff);
   assign row_next   = {1'b0, row_ff} + (FH_W+1)'(1);
   assign frame_done = (row_next >= {1'b0, h_eff});
   assign write_en   = req_acc && !draining_ff && !is_drain;
   assign right_idx  = row_end ? col_ff : col_next[CW-1:0];

   // Next state of the raster tracker and the clearing sweep.
   always_comb begin
      clearing_in  = clearing_ff;
      clear_idx_in = clear_idx_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      swap_in      = swap_ff;
      draining_in  = draining_ff;
      s2_valid_in  = req_acc && emit;
      if (clearing_ff) begin
         clear_idx_in = clear_idx_ff + CW'(1);
         if (clear_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end
      end
      if (req_acc) begin
         if (!draining_ff && !is_drain) begin
            if (row_end) begin
               col_in  = '0;
               swap_in = !swap_ff;
               if (frame_done) begin
                  draining_in = 1'b1;
               end else begin
                  row_in = row_next[FH_W-1:0];
               end
            end else begin
               col_in = col_next[CW-1:0];
            end
         end else if (draining_ff && is_drain) begin
            if (row_end) begin
               col_in      = '0;
               row_in      = '0;
               draining_in = 1'b0;
            end else begin
               col_in = col_next[CW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         swap_ff      <= 1'b0;
         draining_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_idx_ff <= clear_idx_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         swap_ff      <= swap_in;
         draining_ff  <= draining_in;
         s2_valid_ff  <= s2_valid_in;
      end
   end

   // Row stores: zeroed by the sweep after reset, then the older row takes the
   // sample. Reads return the old contents when they meet the write.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         store_a[clear_idx_ff] <= '0;
         store_b[clear_idx_ff] <= '0;
      end else if (write_en) begin
         if (swap_ff) begin
            store_a[col_ff] <= req_bus.lightness;
         end else begin
            store_b[col_ff] <= req_bus.lightness;
         end
      end
      if (req_acc) begin
         rd_a0_ff <= store_a[col_ff];
         rd_a1_ff <= store_a[right_idx];
         rd_b0_ff <= store_b[col_ff];
         rd_b1_ff <= store_b[right_idx];
      end
   end

   // Second stage payload travels alongside the store read data.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s2_swap_ff      <= swap_ff;
         s2_has_left_ff  <= (col_ff != '0);
         s2_has_right_ff <= !row_end;
         s2_use_up_ff    <= use_up;
         s2_row_end_ff   <= row_end;
         s2_frame_end_ff <= row_end && draining_ff;
         s2_down_ff      <= draining_ff ? '0 : req_bus.lightness;
      end
      if (s2_valid_ff) begin
         left_ff <= cen;
      end
   end

   // Pick the neighbours out of the store that plays each role.
   always_comb begin
      cen = s2_swap_ff ? rd_b0_ff : rd_a0_ff;
      rgt = s2_has_right_ff ? (s2_swap_ff ? rd_b1_ff : rd_a1_ff) : '0;
      upr = s2_use_up_ff ? (s2_swap_ff ? rd_a0_ff : rd_b0_ff) : '0;
      lft = s2_has_left_ff ? left_ff : '0;
   end

   assign push               = s2_valid_ff;
   assign push_job.pos       = POS_W'(cen) * POS_W'(CENTRE_GAIN);
   assign push_job.neg       = NEG_W'(lft) + NEG_W'(rgt) + NEG_W'(upr) + NEG_W'(s2_down_ff);
   assign push_job.row_end   = s2_row_end_ff;
   assign push_job.frame_end = s2_frame_end_ff;

   // The credit check must leave a free slot for every push.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
      else $error("front pushed into a full queue");

   // A push always comes from a beat accepted the cycle before.
   a_push_cause: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(req_acc))
      else $error("front pushed without an accepted beat");

endmodule

FILE: rtl/lcs_queue.sv
// ----------------------------------------------------------------------------
// lcs_queue: job queue between front and back end
// Small first-in first-out buffer of pending pixel jobs.
// ----------------------------------------------------------------------------
module lcs_queue
   import lcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  job_type           push_job,
   input  logic              pop,
   output job_type           head_job,
   output logic              head_valid,
   output logic [QCNT_W-1:0] count
);

   job_type           entries [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job   = entries[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

   // Nothing is taken from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue popped while empty");

   // A lone push raises the fill level by exactly one.
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue fill level out of step");

endmodule

FILE: rtl/lcs_back.sv
// ----------------------------------------------------------------------------
// lcs_back: sharpen arithmetic and response register
// Takes jobs from the queue, rounds and clamps the difference and holds the
// result in the response register until the beat is taken.
// ----------------------------------------------------------------------------
module lcs_back
   import lcs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  job_type   head_job,
   input  logic      head_valid,
   output logic      pop,
   lcs_rsp_if.source rsp_bus
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SHARP_W-1:0] sharpened_ff;
   logic               row_end_ff, frame_end_ff;

   logic [DIFF_W-1:0]  diff;
   logic [DIFF_W-1:0]  biased;
   logic [QUO_W-1:0]   quo;
   logic [SHARP_W-1:0] result;

   // Take a job whenever the response register is free or being emptied.
   assign pop = head_valid && (!rsp_valid_ff || rsp_bus.ready);

   // Round half up, floor at zero, ceiling at the largest 9-bit value.
   always_comb begin
      diff   = DIFF_W'(head_job.pos) - DIFF_W'(head_job.neg);
      biased = diff + DIFF_W'(ROUND_BIAS);
      quo    = biased[DIFF_W-2:FRAC_W];
      if (diff[DIFF_W-1] || (diff == '0)) begin
         result = '0;
      end else if (quo > QUO_W'(RESULT_MAX)) begin
         result = SHARP_W'(RESULT_MAX);
      end else begin
         result = quo[SHARP_W-1:0];
      end
   end

   // Response valid.
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         sharpened_ff <= result;
         row_end_ff   <= head_job.row_end;
         frame_end_ff <= head_job.frame_end;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.sharpened = sharpened_ff;
   assign rsp_bus.row_end   = row_end_ff;
   assign rsp_bus.frame_end = frame_end_ff;

   // The last pixel of a frame is always the last pixel of a row.
   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_end_ff) |-> row_end_ff)
      else $error("frame end flagged off a row end");

endmodule

FILE: dv/lightness_cross_sharpen_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lightness_cross_sharpen_checker: result predictor and scoreboard
// Watches the request, response and register ports of the sharpen block. It
// keeps its own copy of the two line stores and the raster position, predicts
// the sharpened pixel, if any, that each accepted request beat makes due, and
// compares each response beat with the oldest prediction.
// ----------------------------------------------------------------------------
module lightness_cross_sharpen_checker
   import lcs_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   lcs_req_if                    req_bus,
   lcs_rsp_if                    rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    pending
);

   // One sharpened pixel as it leaves the block.
   typedef struct packed {
      logic [SHARP_W-1:0] sharpened;
      logic               row_end;
      logic               frame_end;
   } pixel_type;

   // Shadow of the registers, the line stores and the raster position.
   logic [FW_W-1:0]    cfg_cols;
   logic [FH_W-1:0]    cfg_rows;
   logic [LIGHT_W-1:0] row_mem [2][MAX_WIDTH];
   bit                 store_swap;
   int unsigned        col_idx;
   int unsigned        row_idx;
   bit                 draining;
   pixel_type          expected_pixels[$];
   int                 error_total = 0;

   assign mismatches = error_total;

   function automatic int unsigned eff_cols();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > MAX_WIDTH) return MAX_WIDTH;
      return cfg_cols;
   endfunction

   function automatic int unsigned eff_rows();
      return (cfg_rows == 0) ? 1 : cfg_rows;
   endfunction

   // Entry of a line store; columns past the store read as zero.
   function automatic int unsigned line_at(bit which, int unsigned idx);
      return (idx < MAX_WIDTH) ? row_mem[which][idx] : 0;
   endfunction

   // Sharpened pixel at the current column of the previous row, given the
   // samples above and below it.
   function automatic pixel_type sharpen_pixel(int unsigned above, int unsigned below,
                                               int unsigned cols, bit last_row);
      pixel_type   px;
      int unsigned centre;
      int unsigned left;
      int unsigned right;
      int          total;
      int          level;
      centre = line_at(store_swap, col_idx);
      left   = (col_idx > 0) ? line_at(store_swap, col_idx - 1) : 0;
      right  = (col_idx + 1 < cols) ? line_at(store_swap, col_idx + 1) : 0;
      total  = CENTRE_GAIN * int'(centre) - int'(left + right + above + below);
      if (total <= 0) begin
         level = 0;
      end else begin
         level = (total + ROUND_BIAS) >>> FRAC_W;
         if (level > RESULT_MAX) level = RESULT_MAX;
      end
      px.sharpened = level[SHARP_W-1:0];
      px.row_end   = (col_idx + 1 >= cols);
      px.frame_end = px.row_end && last_row;
      return px;
   endfunction

   // Advance the raster position by one request beat and queue any pixel due.
   task automatic predict_beat(logic kind, logic [LIGHT_W-1:0] sample);
      int unsigned cols;
      int unsigned rows;
      int unsigned above;
      cols = eff_cols();
      rows = eff_rows();
      if (!draining) begin
         // Drain ticks before the frame is complete change nothing.
         if (kind == REQ_DRAIN) return;
         if (row_idx > 0) begin
            above = (row_idx > 1) ? line_at(!store_swap, col_idx) : 0;
            expected_pixels.push_back(sharpen_pixel(above, sample, cols, 1'b0));
         end
         if (col_idx < MAX_WIDTH) row_mem[!store_swap][col_idx] = sample;
         if (col_idx + 1 >= cols) begin
            col_idx    = 0;
            store_swap = !store_swap;
            if (row_idx + 1 >= rows) draining = 1'b1;
            else row_idx = (row_idx + 1) & 16'hFFFF;
         end else begin
            col_idx = col_idx + 1;
         end
      end else begin
         // Samples that arrive while the last row is flushed are dropped.
         if (kind == REQ_SAMPLE) return;
         above = (row_idx > 0) ? line_at(!store_swap, col_idx) : 0;
         expected_pixels.push_back(sharpen_pixel(above, 0, cols, 1'b1));
         if (col_idx + 1 >= cols) begin
            col_idx  = 0;
            row_idx  = 0;
            draining = 1'b0;
         end else begin
            col_idx = col_idx + 1;
         end
      end
   endtask

   // Compare one response beat with the oldest prediction.
   task automatic check_pixel();
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         $error("sharpened: no pixel expected, got %0d (row_end %0b, frame_end %0b)",
                rsp_bus.sharpened, rsp_bus.row_end, rsp_bus.frame_end);
         error_total++;
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_bus.sharpened !== want.sharpened) begin
         $error("sharpened: expected %0d, got %0d", want.sharpened, rsp_bus.sharpened);
         error_total++;
      end
      if (rsp_bus.row_end !== want.row_end) begin
         $error("row_end: expected %0b, got %0b", want.row_end, rsp_bus.row_end);
         error_total++;
      end
      if (rsp_bus.frame_end !== want.frame_end) begin
         $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_bus.frame_end);
         error_total++;
      end
   endtask

   // Sample every port at the clock edge. Responses are checked before new
   // requests are predicted, and a register write counts from the next beat.
   always @(posedge clock) begin
      if (reset) begin
         cfg_cols = FRAME_WIDTH_RESET;
         cfg_rows = FRAME_HEIGHT_RESET;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            row_mem[0][i] = '0;
            row_mem[1][i] = '0;
         end
         store_swap = 1'b0;
         col_idx    = 0;
         row_idx    = 0;
         draining   = 1'b0;
         expected_pixels.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_pixel();
         if (req_bus.valid && req_bus.ready) predict_beat(req_bus.req_type, req_bus.lightness);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_FRAME_WIDTH) cfg_cols = csr_pwdata[FW_W-1:0];
            else cfg_rows = csr_pwdata[FH_W-1:0];
         end
      end
      pending <= expected_pixels.size();
   end

endmodule

FILE: dv/lightness_cross_sharpen_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lightness_cross_sharpen_test: testbench top for the lightness sharpen
// Drives frames of lightness samples and drain ticks in bursts, stalls the
// response side on shifting patterns, and reprograms the frame size between
// phases. A separate checker predicts and compares every sharpened pixel.
// ----------------------------------------------------------------------------
module lightness_cross_sharpen_test;
   import lcs_pkg::*;

   localparam int MAX_COLS      = 2048;
   localparam int IDLE_LIMIT    = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_BEATS  = 480;
   localparam int HUGE_ROWS     = 65535;
   localparam int BIG_COLS      = 4095;

   localparam logic [LIGHT_W-1:0] LIGHT_FULL = 15'd25600;
   localparam logic [LIGHT_W-1:0] LIGHT_TOP  = '1;

   // Response-side stall patterns.
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches;
   int                    pending;

   lcs_req_if req_bus ();
   lcs_rsp_if rsp_bus ();

   // Raster position as the stimulus sees it, so that each frame is fed
   // with the right mix of samples and drain ticks.
   logic [FW_W-1:0] cfg_cols = FRAME_WIDTH_RESET;
   logic [FH_W-1:0] cfg_rows = FRAME_HEIGHT_RESET;
   int unsigned     pos_col   = 0;
   int unsigned     pos_row   = 0;
   bit              pos_drain = 1'b0;
   bit              frame_done;
   int unsigned     beats_used = 0;
   int unsigned     burst_left = 0;
   bit              squeeze    = 1'b0;

   // Receiver state.
   rx_mode_type rx_mode;
   int unsigned stretch_left = 0;
   int unsigned hold_left    = 0;
   int unsigned rx_tick      = 0;
   bit          squeezed     = 1'b0;
   int unsigned idle_cycles  = 0;

   always #5 clock = ~clock;

   lightness_cross_sharpen #(
      .MAX_WIDTH(MAX_COLS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   lightness_cross_sharpen_checker #(
      .MAX_WIDTH(MAX_COLS)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_pready (csr_pready),
      .mismatches (mismatches),
      .pending    (pending)
   );

   function automatic int unsigned eff_cols();
      if (cfg_cols == 0) return 1;
      if (cfg_cols > MAX_COLS) return MAX_COLS;
      return cfg_cols;
   endfunction

   function automatic int unsigned eff_rows();
      return (cfg_rows == 0) ? 1 : cfg_rows;
   endfunction

   // Sample values weighted towards the range ends and the saturating region.
   function automatic logic [LIGHT_W-1:0] pick_light();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LIGHT_FULL;
         2: return LIGHT_TOP;
         3: return LIGHT_W'($urandom_range(LIGHT_FULL + 1, LIGHT_TOP));
         default: return LIGHT_W'($urandom_range(0, LIGHT_FULL));
      endcase
   endfunction

   // Track the raster position for one accepted beat; ignored beats leave it.
   task automatic note_beat(logic kind);
      int unsigned cols;
      int unsigned rows;
      cols = eff_cols();
      rows = eff_rows();
      if (!pos_drain) begin
         if (kind == REQ_SAMPLE) begin
            beats_used++;
            if (pos_col + 1 >= cols) begin
               pos_col = 0;
               if (pos_row + 1 >= rows) pos_drain = 1'b1;
               else pos_row++;
            end else begin
               pos_col++;
            end
         end
      end else if (kind == REQ_DRAIN) begin
         beats_used++;
         if (pos_col + 1 >= cols) begin
            pos_col    = 0;
            pos_row    = 0;
            pos_drain  = 1'b0;
            frame_done = 1'b1;
         end else begin
            pos_col++;
         end
      end
   endtask

   // Offer one request beat and wait until it is taken. The sender works in
   // bursts; valid stays high from one beat to the next inside a burst.
   task automatic send_beat(logic kind, logic [LIGHT_W-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 24);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= kind;
      req_bus.lightness <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      note_beat(kind);
   endtask

   // Feed the current frame to its end, or stop after a number of beats.
   // A few beats of the wrong kind are mixed in; the block ignores them.
   task automatic run_frame(int unsigned beat_cap);
      int unsigned start;
      logic        kind;
      start      = beats_used;
      frame_done = 1'b0;
      while (!frame_done && beats_used - start < beat_cap) begin
         kind = pos_drain ? REQ_DRAIN : REQ_SAMPLE;
         if ($urandom_range(0, 11) == 0) kind = !kind;
         send_beat(kind, pick_light());
      end
   endtask

   // Let the block go idle: wait until every pixel is in, then let the pipeline settle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup beat, then access beat until pready.
   task automatic csr_write(logic idx, int unsigned value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      if (idx == REG_FRAME_WIDTH) cfg_cols = value[FW_W-1:0];
      else cfg_rows = value[FH_W-1:0];
   endtask

   task automatic set_frame(int unsigned cols, int unsigned rows);
      csr_write(REG_FRAME_WIDTH, cols);
      csr_write(REG_FRAME_HEIGHT, rows);
   endtask

   // Receiver: changes its stall pattern after each stretch of random length, and once
   // holds off for a long stretch so that the block backs up into the sender.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeezed) begin
            squeezed  = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               rx_mode      = rx_mode_type'($urandom_range(0, 3));
               stretch_left = $urandom_range(10, 100);
            end
            stretch_left--;
            rx_tick++;
            case (rx_mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
               default:   rsp_bus.ready <= (rx_tick % 3 == 0);
            endcase
         end
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("lightness_cross_sharpen_test: FAIL");
         $finish;
      end
   end

   // Stimulus and verdict.
   initial begin
      int unsigned cols;
      int unsigned rows;
      int unsigned cap;
      int unsigned phase;
      int unsigned base;
      int unsigned bulk;
      int unsigned mark;

      reset             <= 1'b1;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= REQ_SAMPLE;
      req_bus.lightness <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Three by two frame: an early drain tick, saturation at the top of
      // row 0, range ends, and a drain tick with a nonzero payload while the last row drains.
      set_frame(3, 2);
      send_beat(REQ_DRAIN, '0);
      send_beat(REQ_SAMPLE, '0);
      send_beat(REQ_SAMPLE, LIGHT_TOP);
      send_beat(REQ_SAMPLE, '0);
      send_beat(REQ_SAMPLE, LIGHT_FULL);
      send_beat(REQ_SAMPLE, '0);
      send_beat(REQ_SAMPLE, LIGHT_TOP);
      send_beat(REQ_SAMPLE, 15'h2AAA);
      send_beat(REQ_DRAIN, '0);
      send_beat(REQ_DRAIN, 15'h5555);
      send_beat(REQ_DRAIN, '0);

      // Single pixel frames, the second one with zero width and height.
      settle();
      set_frame(1, 1);
      send_beat(REQ_SAMPLE, LIGHT_FULL);
      send_beat(REQ_DRAIN, '0);
      settle();
      set_frame(0, 0);
      send_beat(REQ_SAMPLE, LIGHT_TOP);
      send_beat(REQ_DRAIN, '0);

      // Width cut in the middle of row 1 of a four by three frame.
      settle();
      set_frame(4, 3);
      repeat (6) send_beat(REQ_SAMPLE, pick_light());
      settle();
      csr_write(REG_FRAME_WIDTH, 2);
      run_frame(1000);

      // Random frames. Some are cut short and then resized; one frame asks
      // for more than the widest row and is cut short early in its first
      // row, and its beats are not counted in the random budget.
      base  = beats_used;
      bulk  = 0;
      phase = 0;
      while (beats_used - base - bulk < RANDOM_BEATS) begin
         settle();
         phase++;
         if (phase == 4) begin
            set_frame(BIG_COLS, 1);
            mark = beats_used;
            run_frame($urandom_range(20, 60));
            bulk += beats_used - mark;
         end else begin
            if (!squeeze && beats_used - base - bulk > 150) begin
               // Finish the frame in hand, then hold the receiver off
               // through a fresh frame so that the block backs up.
               set_frame(8, 6);
               run_frame(100000);
               settle();
               squeeze = 1'b1;
               run_frame(100000);
               settle();
            end
            case ($urandom_range(0, 9))
               0: cols = 0;
               1: cols = 1;
               2: cols = MAX_COLS;
               3: cols = $urandom_range(13, 40);
               default: cols = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 7))
               0: rows = 0;
               1: rows = 1;
               2: rows = HUGE_ROWS;
               default: rows = $urandom_range(2, 6);
            endcase
            set_frame(cols, rows);
            if (cols >= MAX_COLS || rows == HUGE_ROWS) cap = $urandom_range(5, 60);
            else if ($urandom_range(0, 5) == 0) cap = $urandom_range(1, 40);
            else cap = 100000;
            run_frame(cap);
         end
      end

      // Close the last frame so the block ends at rest.
      settle();
      set_frame($urandom_range(2, 8), $urandom_range(1, 3));
      run_frame(100000);

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("lightness_cross_sharpen_test: PASS");
      end else begin
         $display("lightness_cross_sharpen_test: FAIL");
      end
      $finish;
   end

endmodule
